// ===== src/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg: shared types and constants of the UTF-8 to UTF-16 decoder
// Byte classes, decoder phases, status codes and the queue item layout.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    // Queue depth between classifier and decoder (power of two, at least 2)
    localparam int QUEUE_DEPTH = 2;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    // Result status codes
    localparam logic [1:0] ST_CHAR    = 2'd0;
    localparam logic [1:0] ST_TERM    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_TRUNC   = 2'd3;

    // Limits of a three-byte value
    localparam logic [15:0] MIN_THREE  = 16'h0800;
    localparam logic [15:0] SURR_LO    = 16'hd800;
    localparam logic [15:0] SURR_HI    = 16'hdfff;
    localparam logic [15:0] NONCHAR_LO = 16'hfffe;

    // Class of one input byte
    typedef enum logic [2:0] {
        CLS_ZERO  = 3'd0,
        CLS_ASCII = 3'd1,
        CLS_CONT  = 3'd2,
        CLS_LEAD2 = 3'd3,
        CLS_LEAD3 = 3'd4,
        CLS_BAD   = 3'd5
    } byte_cls_t;

    // Decoder phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_TWO     = 4'b0010,
        PH_THREE_A = 4'b0100,
        PH_THREE_B = 4'b1000
    } phase_t;

    // Classified request passed from front to back
    typedef struct packed {
        byte_cls_t  cls;
        logic [6:0] bits;  // payload bits of the byte
        logic       last;  // last byte of the buffer
    } item_t;

    // Queue status seen by the decoder
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage

// ===== src/utf8d_front.sv =====
// ----------------------------------------------------------------------------
// utf8d_front: input classifier
// Accepts raw bytes while the queue has room and tags each with its class.
// ----------------------------------------------------------------------------
module utf8d_front (
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [utf8d_pkg::S_TDATA_W-1:0]       s_tdata,   // [7:0] data_byte
    input  logic                                  s_tlast,   // last_in_buffer
    input  logic                                  queue_full,
    output logic                                  push,
    output utf8d_pkg::item_t                      push_item
);

    utf8d_pkg::byte_cls_t cls;

    // Accept whenever the queue can take the request
    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    // Classify the byte by range
    always_comb begin
        unique case (s_tdata[7:0]) inside
            8'h00:          cls = utf8d_pkg::CLS_ZERO;
            [8'h01:8'h7f]:  cls = utf8d_pkg::CLS_ASCII;
            [8'h80:8'hbf]:  cls = utf8d_pkg::CLS_CONT;
            [8'hc2:8'hdf]:  cls = utf8d_pkg::CLS_LEAD2;
            [8'he0:8'hef]:  cls = utf8d_pkg::CLS_LEAD3;
            default:        cls = utf8d_pkg::CLS_BAD;
        endcase
    end

    assign push_item.cls  = cls;
    assign push_item.bits = s_tdata[6:0];
    assign push_item.last = s_tlast;

endmodule

// ===== src/utf8d_queue.sv =====
// ----------------------------------------------------------------------------
// utf8d_queue: short request queue
// Register-based FIFO decoupling the classifier from the decoder.
// ----------------------------------------------------------------------------
module utf8d_queue #(
    parameter int DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  utf8d_pkg::item_t       push_item,
    input  logic                   pop,
    output logic                   full,
    output utf8d_pkg::queue_head_t head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    utf8d_pkg::item_t mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (!push && pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming request
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/utf8d_back.sv =====
// ----------------------------------------------------------------------------
// utf8d_back: sequence decoder
// Runs the UTF-8 sequence state machine and holds the result register.
// ----------------------------------------------------------------------------
module utf8d_back (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  utf8d_pkg::queue_head_t                head,
    output logic                                  pop,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [utf8d_pkg::M_TDATA_W-1:0]       m_tdata   // [15:0] code_unit,
                                                            // [17:16] status,
                                                            // [19:18] bytes_used
);

    utf8d_pkg::phase_t phase_reg, phase_next;
    logic [9:0]        part_reg, part_next;
    logic [1:0]        seen_reg, seen_next;
    logic              out_valid_reg, out_valid_next;
    logic [15:0]       unit_reg, unit_next;
    logic [1:0]        status_reg, status_next;
    logic [1:0]        used_reg, used_next;

    logic        emit;
    logic [15:0] emit_unit;
    logic [1:0]  emit_status;
    logic [1:0]  emit_used;
    logic [1:0]  used_inc;
    logic [15:0] val3;
    logic        val3_bad;
    logic        is_cont;

    // Take a request when the result register is free or being drained
    assign pop = head.valid && (!out_valid_reg || m_tready);

    assign used_inc = seen_reg + 2'd1;
    assign is_cont  = (head.item.cls == utf8d_pkg::CLS_CONT);
    assign val3     = {part_reg, head.item.bits[5:0]};
    assign val3_bad = (val3 < utf8d_pkg::MIN_THREE)
                   || ((val3 >= utf8d_pkg::SURR_LO) && (val3 <= utf8d_pkg::SURR_HI))
                   || (val3 >= utf8d_pkg::NONCHAR_LO);

    // Sequence state update
    always_comb begin
        phase_next  = phase_reg;
        part_next   = part_reg;
        seen_next   = seen_reg;
        emit        = 1'b0;
        emit_unit   = '0;
        emit_status = utf8d_pkg::ST_CHAR;
        emit_used   = '0;
        if (pop) begin
            if (head.item.cls == utf8d_pkg::CLS_ZERO) begin
                // Zero byte ends any open sequence
                emit = 1'b1;
                if (phase_reg != utf8d_pkg::PH_IDLE) begin
                    emit_status = utf8d_pkg::ST_INVALID;
                    emit_used   = seen_reg;
                end else begin
                    emit_status = utf8d_pkg::ST_TERM;
                end
            end else begin
                unique case (phase_reg)
                    utf8d_pkg::PH_IDLE: begin
                        unique case (head.item.cls)
                            utf8d_pkg::CLS_ASCII: begin
                                emit      = 1'b1;
                                emit_unit = {9'd0, head.item.bits};
                                emit_used = 2'd1;
                            end
                            utf8d_pkg::CLS_LEAD2: begin
                                phase_next = utf8d_pkg::PH_TWO;
                                part_next  = {5'd0, head.item.bits[4:0]};
                                seen_next  = 2'd1;
                            end
                            utf8d_pkg::CLS_LEAD3: begin
                                phase_next = utf8d_pkg::PH_THREE_A;
                                part_next  = {6'd0, head.item.bits[3:0]};
                                seen_next  = 2'd1;
                            end
                            default: begin
                                emit        = 1'b1;
                                emit_status = utf8d_pkg::ST_INVALID;
                                emit_used   = 2'd1;
                            end
                        endcase
                    end
                    utf8d_pkg::PH_TWO: begin
                        emit      = 1'b1;
                        emit_used = used_inc;
                        if (is_cont) begin
                            emit_unit = {5'd0, part_reg[4:0], head.item.bits[5:0]};
                        end else begin
                            emit_status = utf8d_pkg::ST_INVALID;
                        end
                    end
                    utf8d_pkg::PH_THREE_A: begin
                        if (is_cont) begin
                            phase_next = utf8d_pkg::PH_THREE_B;
                            part_next  = {part_reg[3:0], head.item.bits[5:0]};
                            seen_next  = used_inc;
                        end else begin
                            emit        = 1'b1;
                            emit_status = utf8d_pkg::ST_INVALID;
                            emit_used   = used_inc;
                        end
                    end
                    utf8d_pkg::PH_THREE_B: begin
                        emit      = 1'b1;
                        emit_used = used_inc;
                        if (is_cont && !val3_bad) begin
                            emit_unit = val3;
                        end else begin
                            emit_status = utf8d_pkg::ST_INVALID;
                        end
                    end
                    default: begin
                        emit        = 1'b1;
                        emit_status = utf8d_pkg::ST_INVALID;
                        emit_used   = 2'd1;
                    end
                endcase
                // Flag an open sequence at the end of the buffer
                if (!emit && head.item.last) begin
                    emit        = 1'b1;
                    emit_status = utf8d_pkg::ST_TRUNC;
                    emit_used   = seen_next;
                end
            end
            // Drop back to idle after any result
            if (emit) begin
                phase_next = utf8d_pkg::PH_IDLE;
                part_next  = '0;
                seen_next  = '0;
            end
        end
    end

    // Load or drain the result register
    always_comb begin
        out_valid_next = out_valid_reg;
        unit_next      = unit_reg;
        status_next    = status_reg;
        used_next      = used_reg;
        if (!out_valid_reg || m_tready) begin
            out_valid_next = pop && emit;
            unit_next      = emit_unit;
            status_next    = emit_status;
            used_next      = emit_used;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= utf8d_pkg::PH_IDLE;
            part_reg      <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            part_reg      <= part_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        unit_reg   <= unit_next;
        status_reg <= status_next;
        used_reg   <= used_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, used_reg, status_reg, unit_reg};

endmodule

// ===== src/utf8_to_utf16_decoder_top.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_top: UTF-8 to UTF-16 (BMP) byte-serial decoder
// Byte stream in, one result per completed sequence, error, terminator or
// truncation out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one UTF-8 byte per request in s_tdata[7:0]; s_tlast
//   marks the last byte available in the buffer.
//   Master channel m_*: one result per request: code_unit, status
//   (character, terminator, invalid, truncated) and bytes_used.
//   A byte is written into a short queue when it is accepted; the decoder
//   takes it from the queue when the result register is free or draining
//   and loads the result register, so a result passes through the queue
//   and the result register before it appears on m_tvalid.
//   Throughput is one byte per cycle while the result register is free or
//   draining, set by the decoder step and its result register. Bytes that
//   only open or extend a sequence produce no result.
//   While a result waits with m_tready low the result register holds; the
//   decoder stops, the queue fills and s_tready drops until the result drains.
//   Reset (aresetn low, synchronous) empties the queue and the result
//   register and returns the decoder to idle.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_top #(
    parameter int QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [utf8d_pkg::S_TDATA_W-1:0]       s_tdata,   // [7:0] data_byte
    input  logic                                  s_tlast,   // last_in_buffer
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [utf8d_pkg::M_TDATA_W-1:0]       m_tdata    // [15:0] code_unit,
                                                             // [17:16] status,
                                                             // [19:18] bytes_used
);

    logic                   push;
    logic                   pop;
    logic                   queue_full;
    utf8d_pkg::item_t       push_item;
    utf8d_pkg::queue_head_t head;

    // Classify incoming bytes
    utf8d_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    // Buffer classified requests
    utf8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (queue_full),
        .head      (head)
    );

    // Decode sequences and drive results
    utf8d_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== verif/tb_utf8_to_utf16_decoder_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_decoder_top: self-checking bench of the UTF-8 decoder
// Drives UTF-8 bytes into the slave channel and predicts every decode,
// terminator, error and truncation result. Each result from the master
// channel is compared field by field with the oldest prediction. The bench
// runs directed bytes, then random well-formed and broken sequences under
// several sender idle and receiver stall settings.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_decoder_top;

    localparam int NUM_RANDOM   = 700;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 10;

    // One expected result
    typedef struct packed {
        logic [15:0] unit;
        logic [1:0]  status;
        logic [1:0]  used;
    } decode_t;

    // Predicts decoder results and checks them in order
    class utf8_scoreboard;
        utf8d_pkg::phase_t ph;
        logic [10:0]       acc;
        logic [1:0]        seen;
        decode_t           decoded_q[$];
        int                errors;

        function new();
            ph     = utf8d_pkg::PH_IDLE;
            acc    = '0;
            seen   = '0;
            errors = 0;
        endfunction

        // Queue one result and return the decoder to idle
        function void post_unit(logic [15:0] unit, logic [1:0] status, logic [1:0] used);
            decode_t d;
            d.unit   = unit;
            d.status = status;
            d.used   = used;
            decoded_q.push_back(d);
            ph   = utf8d_pkg::PH_IDLE;
            acc  = '0;
            seen = '0;
        endfunction

        // Advance the decoder by one accepted byte
        function void note_byte(logic [7:0] c, logic last);
            logic        cont;
            logic [1:0]  used;
            logic [15:0] v;
            cont = (c >= 8'h80) && (c <= 8'hbf);
            v    = ({5'd0, acc} << 6) | {10'd0, c[5:0]};
            if (c == 8'h00) begin
                if (ph != utf8d_pkg::PH_IDLE)
                    post_unit(16'd0, utf8d_pkg::ST_INVALID, seen);
                else
                    post_unit(16'd0, utf8d_pkg::ST_TERM, 2'd0);
                return;
            end
            used = seen + 2'd1;
            case (ph)
                utf8d_pkg::PH_IDLE: begin
                    if (c <= 8'h7f) begin
                        post_unit({8'd0, c}, utf8d_pkg::ST_CHAR, 2'd1);
                        return;
                    end
                    if (c >= 8'hc2 && c <= 8'hdf) begin
                        ph  = utf8d_pkg::PH_TWO;
                        acc = {6'd0, c[4:0]};
                    end else if (c >= 8'he0 && c <= 8'hef) begin
                        ph  = utf8d_pkg::PH_THREE_A;
                        acc = {7'd0, c[3:0]};
                    end else begin
                        post_unit(16'd0, utf8d_pkg::ST_INVALID, 2'd1);
                        return;
                    end
                    seen = 2'd1;
                end
                utf8d_pkg::PH_TWO: begin
                    if (!cont)
                        post_unit(16'd0, utf8d_pkg::ST_INVALID, used);
                    else
                        post_unit(v & 16'h07ff, utf8d_pkg::ST_CHAR, used);
                    return;
                end
                utf8d_pkg::PH_THREE_A: begin
                    if (!cont) begin
                        post_unit(16'd0, utf8d_pkg::ST_INVALID, used);
                        return;
                    end
                    acc  = v[10:0];
                    ph   = utf8d_pkg::PH_THREE_B;
                    seen = used;
                end
                default: begin
                    if (!cont || v < utf8d_pkg::MIN_THREE
                            || (v >= utf8d_pkg::SURR_LO && v <= utf8d_pkg::SURR_HI)
                            || v >= utf8d_pkg::NONCHAR_LO)
                        post_unit(16'd0, utf8d_pkg::ST_INVALID, used);
                    else
                        post_unit(v, utf8d_pkg::ST_CHAR, used);
                    return;
                end
            endcase
            // Sequence still open at the end of the buffer
            if (last)
                post_unit(16'd0, utf8d_pkg::ST_TRUNC, seen);
        endfunction

        // Compare one result with the oldest prediction
        function void check_result(logic [utf8d_pkg::M_TDATA_W-1:0] data);
            decode_t want;
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, data);
                errors++;
                return;
            end
            want = decoded_q.pop_front();
            if (data[15:0] !== want.unit) begin
                $display("%0t: code_unit expected %h actual %h", $time, want.unit, data[15:0]);
                errors++;
            end
            if (data[17:16] !== want.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, data[17:16]);
                errors++;
            end
            if (data[19:18] !== want.used) begin
                $display("%0t: bytes_used expected %0d actual %0d",
                         $time, want.used, data[19:18]);
                errors++;
            end
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [utf8d_pkg::S_TDATA_W-1:0] s_tdata  = '0;   // [7:0] data_byte
    logic                            s_tlast  = 1'b0; // last_in_buffer
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [utf8d_pkg::M_TDATA_W-1:0] m_tdata;         // [15:0] code_unit,
                                                      // [17:16] status,
                                                      // [19:18] bytes_used

    utf8_scoreboard sb;
    int  send_gap_pct  = 0;
    int  stall_pct     = 0;
    bit  hold_request  = 0;
    int  bytes_sent    = 0;
    int  quiet_cycles  = 0;

    utf8_to_utf16_decoder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Receiver: random stalls, or a long hold-off on request
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
                @(posedge aclk);
            end
        end
    end

    // Check every accepted result
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Abort when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one request and hold it until accepted
    task automatic send_byte(input logic [7:0] c, input logic last);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_byte(c, last);
        bytes_sent++;
    endtask

    function automatic logic rand_last();
        return $urandom_range(24) == 0;
    endfunction

    function automatic logic [7:0] rand_cont();
        return 8'(8'h80 + $urandom_range(63));
    endfunction

    // One random sequence, mostly well formed
    task automatic send_random_sequence();
        int         pick;
        logic [7:0] lead;
        pick = $urandom_range(99);
        if (pick < 30) begin
            send_byte(8'($urandom_range(8'h7f, 8'h01)), rand_last());
        end else if (pick < 50) begin
            send_byte(8'($urandom_range(8'hdf, 8'hc2)), rand_last());
            send_byte(rand_cont(), rand_last());
        end else if (pick < 75) begin
            lead = 8'($urandom_range(8'hef, 8'he0));
            // lean towards the edges of the three-byte range
            if ($urandom_range(3) == 0)
                lead = $urandom_range(1) ? 8'hef : 8'he0;
            send_byte(lead, rand_last());
            send_byte(rand_cont(), rand_last());
            send_byte(rand_cont(), rand_last());
        end else if (pick < 80) begin
            send_byte(8'h00, rand_last());
        end else if (pick < 88) begin
            // sequence cut short by the end of the buffer
            if ($urandom_range(1)) begin
                send_byte(8'($urandom_range(8'hdf, 8'hc2)), 1'b1);
            end else begin
                send_byte(8'($urandom_range(8'hef, 8'he0)), 1'b0);
                send_byte(rand_cont(), 1'b1);
            end
        end else if (pick < 95) begin
            // lead, an optional continuation, then any byte
            send_byte(8'($urandom_range(8'hef, 8'hc2)), rand_last());
            if ($urandom_range(1))
                send_byte(rand_cont(), rand_last());
            send_byte(8'($urandom_range(255)), rand_last());
        end else begin
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    initial begin
        int plan_gap[4];
        int plan_stall[4];
        sb = new();
        plan_gap   = '{0, 63, 0, 32};
        plan_stall = '{0, 0, 63, 32};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: range edges and error cases
        send_byte(8'h00, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'hc1, 1'b0);
        send_byte(8'hc2, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hdf, 1'b0); send_byte(8'hbf, 1'b0);
        send_byte(8'he0, 1'b0); send_byte(8'h9f, 1'b0); send_byte(8'hbf, 1'b0);
        send_byte(8'hed, 1'b0); send_byte(8'ha0, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hef, 1'b0); send_byte(8'hbf, 1'b0); send_byte(8'hbe, 1'b0);
        send_byte(8'he1, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h41, 1'b0);
        send_byte(8'hc2, 1'b0); send_byte(8'hff, 1'b0);
        send_byte(8'he1, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'he2, 1'b0); send_byte(8'h82, 1'b1);
        send_byte(8'hff, 1'b1);

        // Random phases under different idle and stall settings
        for (int p = 0; p < 4; p++) begin
            send_gap_pct = plan_gap[p];
            stall_pct    = plan_stall[p];
            if (p == 0)
                hold_request = 1;
            while (bytes_sent < 26 + (p + 1) * NUM_RANDOM / 4)
                send_random_sequence();
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
